/* hw/rtl/zsbt_pkg.sv */
// Shared constants, types and state encoding for the Zhang-Suen thinning core.
// No dependencies; every other file of the core except zsbt_ram imports this package.
package zsbt_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;

   // register field width and dimension reset value
   localparam int CFG_W     = 9;
   localparam int RESET_DIM = 256;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   // room for a dimension plus a small offset in compares
   localparam int WDIM_W = $clog2(MAX_WIDTH + 2);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 2);

   localparam int PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_ON  = 8'd255;
   localparam logic [PIX_W-1:0] PIX_OFF = 8'd0;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [0:0] REG_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HEIGHT = 1'b1;

   localparam logic REQ_LOAD = 1'b0;

   localparam int NBR_MIN = 2;
   localparam int NBR_MAX = 6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LPAD,
      ST_RFETCH,
      ST_REMIT,
      ST_SP_FILL,
      ST_ROW_RUN,
      ST_ROW_WB,
      ST_ROW_NEXT
   } zsbt_state_type;

   typedef struct packed {
      logic [WDIM_W-1:0] width;
      logic [HDIM_W-1:0] height;
      logic              restart;
   } zsbt_cfg_type;

endpackage

/* hw/rtl/zsbt_req_if.sv */
// Request channel of the thinning core: valid/ready plus load/read payload.
// Depends on zsbt_pkg.
interface zsbt_req_if import zsbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             req_type;
   logic [PIX_W-1:0] pixel_value;

   modport source (output valid, output req_type, output pixel_value, input ready);
   modport sink   (input valid, input req_type, input pixel_value, output ready);
endinterface

/* hw/rtl/zsbt_rsp_if.sv */
// Response channel of the thinning core: valid/ready plus readout payload.
// Depends on zsbt_pkg.
interface zsbt_rsp_if import zsbt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_out;
   logic             last_pixel;
   logic             no_frame;

   modport source (output valid, output pixel_out, output last_pixel, output no_frame,
                   input ready);
   modport sink   (input valid, input pixel_out, input last_pixel, input no_frame,
                   output ready);
endinterface

/* hw/rtl/zhang_suen_binary_thinning_core.sv */
// Zhang-Suen thinning core. The load ending a row is followed by the row alignment
// shift and the row write to image RAM; a read at a row start first fetches the row
// from image RAM. The last load starts thinning when width and height are at least 3:
// each subpass prefills the window and then runs the interior rows, two subpasses
// per iteration, iterations until nothing changes; not ready meanwhile.
// Synchronous active-high reset clears control state; image RAM needs no clearing.
module zhang_suen_binary_thinning_core import zsbt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   zsbt_req_if.sink          req_chan,
   zsbt_rsp_if.source        rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   zsbt_cfg_type cfg;

   zsbt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // control state
   zsbt_state_type    state_ff, state_in;
   logic [COL_W-1:0]  load_col_ff, load_col_in;
   logic [ROW_W-1:0]  load_row_ff, load_row_in;
   logic [WDIM_W-1:0] pad_cnt_ff, pad_cnt_in;
   logic [COL_W-1:0]  rd_col_ff, rd_col_in;
   logic [ROW_W-1:0]  rd_row_ff, rd_row_in;
   logic              frame_ready_ff, frame_ready_in;
   logic              changed_ff, changed_in;     // iteration cleared a pixel
   logic              second_ff, second_in;       // subpass select
   logic [1:0]        fill_ff, fill_in;           // window prefill step
   logic [COL_W-1:0]  step_ff, step_in;           // rotation step in a row
   logic [ROW_W-1:0]  t_row_ff, t_row_in;         // row under thinning
   logic              out_valid_ff, out_valid_in;

   // payload
   logic [MAX_WIDTH-1:0] lbuf_ff, lbuf_in;        // row being loaded
   logic [MAX_WIDTH-1:0] rbuf_ff, rbuf_in;        // row being read out
   logic [MAX_WIDTH-1:0] prev_ff, prev_in;        // original rows r-1, r, r+1
   logic [MAX_WIDTH-1:0] cur_ff, cur_in;
   logic [MAX_WIDTH-1:0] next_ff, next_in;
   logic [MAX_WIDTH-1:0] new_ff, new_in;          // thinned row r
   logic [PIX_W-1:0]     out_pixel_ff, out_pixel_in;
   logic                 out_last_ff, out_last_in;
   logic                 out_nofr_ff, out_nofr_in;

   // image RAM, one row per word
   logic                 ram_we;
   logic [ROW_W-1:0]     ram_waddr;
   logic [MAX_WIDTH-1:0] ram_wdata;
   logic [ROW_W-1:0]     ram_raddr;
   logic [MAX_WIDTH-1:0] ram_rdata;

   zsbt_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_image (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared neighborhood unit; window taps are the low three bits of each row
   logic mark;

   zsbt_eval u_eval (
      .north_row (prev_ff[2:0]),
      .mid_row   (cur_ff[2:0]),
      .south_row (next_ff[2:0]),
      .second    (second_ff),
      .mark      (mark)
   );

   logic out_free, req_fire, pix_bit;
   logic load_col_end, load_row_end, rd_col_end, rd_row_end;
   logic col_interior, row_last, thin_ok, new_bit;
   logic emit, shift_in, rotate;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign pix_bit  = req_chan.pixel_value[PIX_W-1];   // 128 and up is foreground

   assign load_col_end = (WDIM_W'(load_col_ff) + WDIM_W'(1)) == cfg.width;
   assign load_row_end = (HDIM_W'(load_row_ff) + HDIM_W'(1)) == cfg.height;
   assign rd_col_end   = (WDIM_W'(rd_col_ff) + WDIM_W'(1)) == cfg.width;
   assign rd_row_end   = (HDIM_W'(rd_row_ff) + HDIM_W'(1)) == cfg.height;
   // center column is step+1; interior when step+2 < width (wrap never qualifies)
   assign col_interior = (WDIM_W'(step_ff) + WDIM_W'(2)) < cfg.width;
   assign row_last     = (HDIM_W'(t_row_ff) + HDIM_W'(2)) == cfg.height;
   assign thin_ok      = (cfg.width >= WDIM_W'(3)) && (cfg.height >= HDIM_W'(3));
   assign new_bit      = cur_ff[1] & ~(mark & col_interior);

   always_comb begin
      state_in       = state_ff;
      load_col_in    = load_col_ff;
      load_row_in    = load_row_ff;
      pad_cnt_in     = pad_cnt_ff;
      rd_col_in      = rd_col_ff;
      rd_row_in      = rd_row_ff;
      frame_ready_in = frame_ready_ff;
      changed_in     = changed_ff;
      second_in      = second_ff;
      fill_in        = fill_ff;
      step_in        = step_ff;
      t_row_in       = t_row_ff;
      out_valid_in   = out_valid_ff;
      lbuf_in        = lbuf_ff;
      rbuf_in        = rbuf_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      next_in        = next_ff;
      new_in         = new_ff;
      out_pixel_in   = out_pixel_ff;
      out_last_in    = out_last_ff;
      out_nofr_in    = out_nofr_ff;
      ram_we         = 1'b0;
      ram_waddr      = t_row_ff;
      ram_wdata      = new_ff;
      ram_raddr      = t_row_ff;
      emit           = 1'b0;
      shift_in       = 1'b0;
      rotate         = 1'b0;

      if (out_valid_ff && rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.req_type == REQ_LOAD) begin
                  // a load drops any finished frame
                  frame_ready_in = 1'b0;
                  rd_col_in      = '0;
                  rd_row_in      = '0;
                  lbuf_in        = {pix_bit, lbuf_ff[MAX_WIDTH-1:1]};
                  if (load_col_end) begin
                     load_col_in = '0;
                     pad_cnt_in  = WDIM_W'(MAX_WIDTH) - cfg.width;
                     state_in    = ST_LPAD;
                  end else begin
                     load_col_in = load_col_ff + 1'b1;
                  end
               end else if (!frame_ready_ff) begin
                  out_valid_in = 1'b1;
                  out_pixel_in = PIX_OFF;
                  out_last_in  = 1'b0;
                  out_nofr_in  = 1'b1;
               end else if (rd_col_ff == '0) begin
                  ram_raddr = rd_row_ff;
                  state_in  = ST_RFETCH;
               end else begin
                  emit = 1'b1;
               end
            end
         end
         ST_LPAD: begin
            // finish aligning the row so column c lands on bit c
            if (pad_cnt_ff != '0) begin
               lbuf_in    = {1'b0, lbuf_ff[MAX_WIDTH-1:1]};
               pad_cnt_in = pad_cnt_ff - 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = load_row_ff;
               ram_wdata = lbuf_ff;
               if (load_row_end) begin
                  load_row_in = '0;
                  if (thin_ok) begin
                     changed_in = 1'b0;
                     second_in  = 1'b0;
                     fill_in    = '0;
                     state_in   = ST_SP_FILL;
                  end else begin
                     // no interior: frame goes out as loaded
                     frame_ready_in = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end else begin
                  load_row_in = load_row_ff + 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_RFETCH: begin
            rbuf_in  = ram_rdata;
            state_in = ST_REMIT;
         end
         ST_REMIT: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SP_FILL: begin
            // reads rows 0..2 back to back, window fills in the cycle after each read
            ram_raddr = ROW_W'(fill_ff);
            fill_in   = fill_ff + 1'b1;
            if (fill_ff != '0) begin
               shift_in = 1'b1;
            end
            if (fill_ff == 2'd3) begin
               t_row_in = ROW_W'(1);
               step_in  = '0;
               state_in = ST_ROW_RUN;
            end
         end
         ST_ROW_RUN: begin
            rotate = 1'b1;
            if (mark && col_interior) begin
               changed_in = 1'b1;
            end
            if (step_ff == COL_W'(MAX_WIDTH - 1)) begin
               step_in  = '0;
               state_in = ST_ROW_WB;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROW_WB: begin
            // rows above stay in the window registers, so write back at once
            ram_we = 1'b1;
            if (row_last) begin
               if (!second_ff) begin
                  second_in = 1'b1;
                  fill_in   = '0;
                  state_in  = ST_SP_FILL;
               end else if (changed_ff) begin
                  changed_in = 1'b0;
                  second_in  = 1'b0;
                  fill_in    = '0;
                  state_in   = ST_SP_FILL;
               end else begin
                  frame_ready_in = 1'b1;
                  rd_col_in      = '0;
                  rd_row_in      = '0;
                  state_in       = ST_IDLE;
               end
            end else begin
               ram_raddr = t_row_ff + ROW_W'(2);
               t_row_in  = t_row_ff + 1'b1;
               state_in  = ST_ROW_NEXT;
            end
         end
         ST_ROW_NEXT: begin
            shift_in = 1'b1;
            state_in = ST_ROW_RUN;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
         out_pixel_in = rbuf_ff[0] ? PIX_ON : PIX_OFF;
         out_last_in  = rd_col_end && rd_row_end;
         out_nofr_in  = 1'b0;
         rbuf_in      = {1'b0, rbuf_ff[MAX_WIDTH-1:1]};
         if (rd_col_end) begin
            rd_col_in = '0;
            if (rd_row_end) begin
               rd_row_in      = '0;
               frame_ready_in = 1'b0;
            end else begin
               rd_row_in = rd_row_ff + 1'b1;
            end
         end else begin
            rd_col_in = rd_col_ff + 1'b1;
         end
      end

      if (shift_in) begin
         prev_in = cur_ff;
         cur_in  = next_ff;
         next_in = ram_rdata;
         new_in  = next_ff;
      end

      if (rotate) begin
         prev_in = {prev_ff[0], prev_ff[MAX_WIDTH-1:1]};
         cur_in  = {cur_ff[0], cur_ff[MAX_WIDTH-1:1]};
         next_in = {next_ff[0], next_ff[MAX_WIDTH-1:1]};
         new_in  = {new_ff[0], new_ff[MAX_WIDTH-1:2], new_bit};
      end

      // register write restarts the frame
      if (cfg.restart) begin
         load_col_in    = '0;
         load_row_in    = '0;
         rd_col_in      = '0;
         rd_row_in      = '0;
         frame_ready_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         load_col_ff    <= '0;
         load_row_ff    <= '0;
         pad_cnt_ff     <= '0;
         rd_col_ff      <= '0;
         rd_row_ff      <= '0;
         frame_ready_ff <= 1'b0;
         changed_ff     <= 1'b0;
         second_ff      <= 1'b0;
         fill_ff        <= '0;
         step_ff        <= '0;
         t_row_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         load_col_ff    <= load_col_in;
         load_row_ff    <= load_row_in;
         pad_cnt_ff     <= pad_cnt_in;
         rd_col_ff      <= rd_col_in;
         rd_row_ff      <= rd_row_in;
         frame_ready_ff <= frame_ready_in;
         changed_ff     <= changed_in;
         second_ff      <= second_in;
         fill_ff        <= fill_in;
         step_ff        <= step_in;
         t_row_ff       <= t_row_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lbuf_ff      <= lbuf_in;
      rbuf_ff      <= rbuf_in;
      prev_ff      <= prev_in;
      cur_ff       <= cur_in;
      next_ff      <= next_in;
      new_ff       <= new_in;
      out_pixel_ff <= out_pixel_in;
      out_last_ff  <= out_last_in;
      out_nofr_ff  <= out_nofr_in;
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pixel_out  = out_pixel_ff;
   assign rsp_chan.last_pixel = out_last_ff;
   assign rsp_chan.no_frame   = out_nofr_ff;

   // a no-frame transaction carries a blank pixel and is never the frame end
   a_nofr_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.no_frame) |->
      (rsp_chan.pixel_out == PIX_OFF && !rsp_chan.last_pixel))
      else $error("no-frame response with pixel data");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      cfg.restart |=> (!frame_ready_ff && load_col_ff == '0 && rd_col_ff == '0))
      else $error("register write did not restart the frame");

   a_load_col: assert property (@(posedge clock) disable iff (reset)
      (WDIM_W'(load_col_ff) < cfg.width))
      else $error("load column past image width");

   // the end of thinning always publishes a frame
   a_thin_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW_WB && state_in == ST_IDLE) |=> frame_ready_ff)
      else $error("thinning finished without a ready frame");

endmodule

/* hw/rtl/zsbt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module zsbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/zsbt_csr.sv */
// APB-style register block: image width and height, clamped effective sizes.
// Depends on zsbt_pkg.
module zsbt_csr import zsbt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output zsbt_cfg_type      cfg
);

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic             wr;
   logic [0:0]       idx;

   assign wr  = csr_psel && csr_penable && csr_pwrite;
   assign idx = csr_paddr[CSR_AW-1:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (idx)
            REG_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_W'(RESET_DIM);
         height_ff <= CFG_W'(RESET_DIM);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // zero means one, anything past the maximum means the maximum
   always_comb begin
      if (width_ff == '0) begin
         cfg.width = WDIM_W'(1);
      end else if (int'(width_ff) > MAX_WIDTH) begin
         cfg.width = WDIM_W'(MAX_WIDTH);
      end else begin
         cfg.width = WDIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         cfg.height = HDIM_W'(1);
      end else if (int'(height_ff) > MAX_HEIGHT) begin
         cfg.height = HDIM_W'(MAX_HEIGHT);
      end else begin
         cfg.height = HDIM_W'(height_ff);
      end
      cfg.restart = wr;
   end

endmodule

/* hw/rtl/zsbt_eval.sv */
// 3x3 neighborhood test of one Zhang-Suen subpass; shared by every pixel.
// Depends on zsbt_pkg.
module zsbt_eval import zsbt_pkg::*; (
   input  logic [2:0] north_row,   // bit 0 west, bit 1 center, bit 2 east
   input  logic [2:0] mid_row,
   input  logic [2:0] south_row,
   input  logic       second,
   output logic       mark
);

   logic [7:0] n;
   logic [3:0] cnt;
   logic [3:0] trans;
   logic       m1, m2;

   // clockwise from north
   assign n = {north_row[0], mid_row[0], south_row[0], south_row[1],
               south_row[2], mid_row[2], north_row[2], north_row[1]};

   always_comb begin
      cnt   = '0;
      trans = '0;
      for (int k = 0; k < 8; k++) begin
         cnt = cnt + 4'(n[k]);
         if (!n[k] && n[3'(k + 1)]) begin
            trans = trans + 4'd1;
         end
      end
      if (!second) begin
         m1 = n[0] & n[2] & n[4];
         m2 = n[2] & n[4] & n[6];
      end else begin
         m1 = n[0] & n[2] & n[6];
         m2 = n[0] & n[4] & n[6];
      end
      mark = mid_row[1] && (trans == 4'd1) && (cnt >= 4'(NBR_MIN)) &&
             (cnt <= 4'(NBR_MAX)) && !m1 && !m2;
   end

endmodule
